// ===== sv/pcfp_pkg.sv =====
// Shared types and constants for the PWM command frame parser.
// Depends on nothing; every other file of the block imports it.
package pcfp_pkg;

   // Frame layout: '$' f f f ':' u ':' d d d '$' newline.
   localparam int FRAME_LEN  = 12;
   localparam int STORED_LEN = FRAME_LEN - 1;
   localparam int COUNT_WIDTH = 4;

   localparam int POS_START  = 0;
   localparam int POS_FREQ   = 1;
   localparam int POS_SEP_A  = 4;
   localparam int POS_UNIT   = 5;
   localparam int POS_SEP_B  = 6;
   localparam int POS_DUTY   = 7;
   localparam int POS_END    = 10;

   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam int TICK_WIDTH     = 24;
   localparam int FREQ_WIDTH     = 20;
   localparam int DUTY_WIDTH     = 10;
   localparam int PERIOD_WIDTH   = 17;
   localparam int RELOAD_WIDTH   = 16;
   localparam int PCT_WIDTH      = 7;
   localparam int DIV_CNT_WIDTH  = $clog2(TICK_WIDTH);

   // Division by 100 as a multiplication by ceil(2^30 / 100) and a shift by 30.
   // The rounding error is 76 / 2^30 per unit, so the quotient is exact for
   // every product below 2^30 / 76, which covers 100 * 65536.
   localparam int SCALED_WIDTH = 2 * TICK_WIDTH;
   localparam int RECIP_SHIFT  = 30;

   localparam logic [TICK_WIDTH-1:0]   TICK_RATE_RESET = 24'd1000000;
   localparam logic [TICK_WIDTH-1:0]   MAX_PERIOD      = 24'd65536;
   localparam logic [DUTY_WIDTH-1:0]   MAX_DUTY        = 10'd100;
   localparam logic [FREQ_WIDTH-1:0]   PERCENT_DIVISOR = 20'd100;
   localparam logic [FREQ_WIDTH-1:0]   KHZ_SCALE       = 20'd1000;
   localparam logic [TICK_WIDTH-1:0]   RECIP_100       = 24'd10737419;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_FORMAT    = 3'd1,
      STATUS_ZERO_FREQ = 3'd2,
      STATUS_DUTY      = 3'd3,
      STATUS_LONG      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_CHECK,
      STATE_DIV_PERIOD,
      STATE_MUL,
      STATE_SCALE,
      STATE_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        accept;
      logic        store;
      logic        clear_count;
      logic        take_duty;
      logic        div_start;
      logic        take_period;
      logic        take_product;
      logic        load_rsp;
      status_type  rsp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_slot;
      logic newline;
      logic format_ok;
      logic freq_zero;
      logic duty_over;
      logic div_done;
      logic period_long;
   } stat_type;

endpackage

// ===== sv/pcfp_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on pcfp_pkg for the operand widths.
module pcfp_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pcfp_pkg::TICK_WIDTH-1:0] dividend,
   input  logic [pcfp_pkg::FREQ_WIDTH-1:0] divisor,
   output logic                            done,
   output logic [pcfp_pkg::TICK_WIDTH-1:0] quotient
);
   import pcfp_pkg::*;

   logic                     busy_ff;
   logic                     done_ff;
   logic [DIV_CNT_WIDTH-1:0] count_ff;
   logic [FREQ_WIDTH-1:0]    rem_ff;
   logic [FREQ_WIDTH-1:0]    divisor_ff;
   logic [TICK_WIDTH-1:0]    quot_ff;
   logic [FREQ_WIDTH:0]      shifted;
   logic [FREQ_WIDTH:0]      diff;
   logic                     fits;

   // The partial remainder stays below the divisor, so the shifted value
   // is below twice the divisor and one subtraction settles each bit.
   always_comb begin
      shifted = {rem_ff, quot_ff[TICK_WIDTH-1]};
      diff    = shifted - {1'b0, divisor_ff};
      fits    = shifted >= {1'b0, divisor_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= DIV_CNT_WIDTH'(TICK_WIDTH - 1);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quot_ff    <= dividend;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[FREQ_WIDTH-1:0] : shifted[FREQ_WIDTH-1:0];
         quot_ff <= {quot_ff[TICK_WIDTH-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== sv/pcfp_dpath.sv =====
// Datapath: frame byte store, format checks, operand decode, the period
// divider, the duty multiplier, the percent scaling and the result registers.
// Depends on pcfp_pkg and pcfp_div.
module pcfp_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        req_rx_byte,
   input  logic                              csr_write_enable,
   input  logic [pcfp_pkg::TICK_WIDTH-1:0]   csr_write_data,
   input  pcfp_pkg::cmd_type                 cmd,
   output pcfp_pkg::stat_type                stat,
   output logic [2:0]                        rsp_status,
   output logic [pcfp_pkg::RELOAD_WIDTH-1:0] rsp_period_reload,
   output logic [pcfp_pkg::PERIOD_WIDTH-1:0] rsp_compare_value
);
   import pcfp_pkg::*;

   logic [7:0]              frame_ff [STORED_LEN];
   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [7:0]              last_ff;
   logic [TICK_WIDTH-1:0]   tick_rate_ff;
   logic [DUTY_WIDTH-1:0]   duty_ff;
   logic [PERIOD_WIDTH-1:0] period_ff;
   logic [TICK_WIDTH-1:0]   product_ff;
   logic [2:0]              status_ff;
   logic [RELOAD_WIDTH-1:0] reload_ff;
   logic [PERIOD_WIDTH-1:0] compare_ff;

   logic                    digits_ok;
   logic [DUTY_WIDTH-1:0]   freq_digits;
   logic [DUTY_WIDTH-1:0]   duty_digits;
   logic [FREQ_WIDTH-1:0]   freq_hz;
   logic                    div_done;
   logic [TICK_WIDTH-1:0]   div_quotient;
   logic [PERIOD_WIDTH-1:0] period_sat;
   logic [SCALED_WIDTH-1:0] scaled;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   function automatic logic [DUTY_WIDTH-1:0] three_digits(input logic [7:0] h,
                                                          input logic [7:0] t,
                                                          input logic [7:0] u);
      logic [3:0] dh, dt, du;
      dh = 4'(h - CHAR_ZERO);
      dt = 4'(t - CHAR_ZERO);
      du = 4'(u - CHAR_ZERO);
      return DUTY_WIDTH'(dh) * DUTY_WIDTH'(100) + DUTY_WIDTH'(dt) * DUTY_WIDTH'(10)
           + DUTY_WIDTH'(du);
   endfunction

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= TICK_RATE_RESET;
      end else if (csr_write_enable) begin
         tick_rate_ff <= csr_write_data;
      end
   end

   // Byte counter and frame store.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear_count) begin
         count_ff <= '0;
      end else if (cmd.store) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         frame_ff[count_ff] <= req_rx_byte;
      end
      if (cmd.accept) begin
         last_ff <= req_rx_byte;
      end
   end

   // Frame decode, valid in the check state once the last byte is latched.
   always_comb begin
      digits_ok = is_digit(frame_ff[POS_FREQ])     && is_digit(frame_ff[POS_FREQ + 1]) &&
                  is_digit(frame_ff[POS_FREQ + 2]) && is_digit(frame_ff[POS_DUTY]) &&
                  is_digit(frame_ff[POS_DUTY + 1]) && is_digit(frame_ff[POS_DUTY + 2]);
      freq_digits = three_digits(frame_ff[POS_FREQ], frame_ff[POS_FREQ + 1],
                                 frame_ff[POS_FREQ + 2]);
      duty_digits = three_digits(frame_ff[POS_DUTY], frame_ff[POS_DUTY + 1],
                                 frame_ff[POS_DUTY + 2]);
      if (frame_ff[POS_UNIT] == CHAR_ZERO) begin
         freq_hz = FREQ_WIDTH'(freq_digits);
      end else begin
         freq_hz = FREQ_WIDTH'(freq_digits) * KHZ_SCALE;
      end
   end

   assign stat.last_slot   = (count_ff == COUNT_WIDTH'(STORED_LEN));
   assign stat.newline     = (req_rx_byte == CHAR_NEWLINE);
   assign stat.format_ok   = (last_ff == CHAR_NEWLINE) &&
                             (frame_ff[POS_START] == CHAR_DOLLAR) &&
                             (frame_ff[POS_END] == CHAR_DOLLAR) &&
                             (frame_ff[POS_SEP_A] == CHAR_COLON) &&
                             (frame_ff[POS_SEP_B] == CHAR_COLON) && digits_ok;
   assign stat.freq_zero   = (freq_digits == '0);
   assign stat.duty_over   = (duty_digits > MAX_DUTY);
   assign stat.div_done    = div_done;
   assign stat.period_long = (div_quotient > MAX_PERIOD);

   // The divider computes tick_rate / frequency.
   pcfp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (tick_rate_ff),
      .divisor  (freq_hz),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // A zero quotient saturates to a period of one.
   assign period_sat = (div_quotient == '0) ? PERIOD_WIDTH'(1)
                                            : div_quotient[PERIOD_WIDTH-1:0];

   // The compare value is product / 100, taken from the reciprocal product.
   assign scaled = SCALED_WIDTH'(product_ff) * SCALED_WIDTH'(RECIP_100);

   always_ff @(posedge clock) begin
      if (cmd.take_duty) begin
         duty_ff <= duty_digits;
      end
      if (cmd.take_period) begin
         period_ff <= period_sat;
      end
      if (cmd.take_product) begin
         product_ff <= TICK_WIDTH'(duty_ff[PCT_WIDTH-1:0]) * TICK_WIDTH'(period_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= cmd.rsp_status;
         if (cmd.rsp_status == STATUS_OK) begin
            reload_ff  <= RELOAD_WIDTH'(period_ff - 1'b1);
            compare_ff <= scaled[RECIP_SHIFT +: PERIOD_WIDTH];
         end else begin
            reload_ff  <= '0;
            compare_ff <= '0;
         end
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_period_reload = reload_ff;
   assign rsp_compare_value = compare_ff;

endmodule

// ===== sv/pcfp_ctrl.sv =====
// Controller state machine: byte intake, judging sequence and result hold.
// Depends on pcfp_pkg.
module pcfp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  pcfp_pkg::stat_type  stat,
   output pcfp_pkg::cmd_type   cmd
);
   import pcfp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = STATUS_OK;
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;
      unique case (state_ff)
         STATE_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.last_slot) begin
                  cmd.clear_count = 1'b1;
                  state_in        = STATE_CHECK;
               end else if (stat.newline) begin
                  cmd.clear_count = 1'b1;
                  cmd.load_rsp    = 1'b1;
                  cmd.rsp_status  = STATUS_FORMAT;
                  state_in        = STATE_OUT;
               end else begin
                  cmd.store = 1'b1;
               end
            end
         end
         STATE_CHECK: begin
            cmd.take_duty = 1'b1;
            if (!stat.format_ok) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = STATUS_FORMAT;
               state_in       = STATE_OUT;
            end else if (stat.freq_zero) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = STATUS_ZERO_FREQ;
               state_in       = STATE_OUT;
            end else if (stat.duty_over) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = STATUS_DUTY;
               state_in       = STATE_OUT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = STATE_DIV_PERIOD;
            end
         end
         STATE_DIV_PERIOD: begin
            if (stat.div_done) begin
               if (stat.period_long) begin
                  cmd.load_rsp   = 1'b1;
                  cmd.rsp_status = STATUS_LONG;
                  state_in       = STATE_OUT;
               end else begin
                  cmd.take_period = 1'b1;
                  state_in        = STATE_MUL;
               end
            end
         end
         STATE_MUL: begin
            cmd.take_product = 1'b1;
            state_in         = STATE_SCALE;
         end
         STATE_SCALE: begin
            cmd.load_rsp   = 1'b1;
            cmd.rsp_status = STATUS_OK;
            state_in       = STATE_OUT;
         end
         STATE_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/pwm_command_frame_parser.sv =====
// Top level of the PWM command frame parser: joins controller and datapath.
// Depends on pcfp_pkg, pcfp_ctrl, pcfp_dpath and pcfp_div.
//
//   Port group   Direction   Contents
//   req_         in          one received byte per beat (rx_byte)
//   rsp_         out         status, period_reload, compare_value per beat
//   csr_         in          write of tick_rate, taken on any enabled edge
//
// A byte that is stored or that is an early newline is handled in the idle
// state; an early newline then presents its result in the next cycle.
// The byte that completes a frame keeps the block busy for a check state,
// the restoring period divider (24 quotient bits and a done flag), a multiply
// state and a state dividing by 100 through a reciprocal multiplication, then
// offers its result; a failed check or a period over 65536 ends the run early.
// Synchronous reset returns the controller to idle, clears the byte count
// and loads tick_rate with its default of 1000000.
// req_stall is high whenever the controller is not idle; a result beat is
// held on rsp_ until it is taken, and no byte is accepted meanwhile.
module pwm_command_frame_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic [pcfp_pkg::RELOAD_WIDTH-1:0] rsp_period_reload,
   output logic [pcfp_pkg::PERIOD_WIDTH-1:0] rsp_compare_value,
   input  logic                              csr_write_enable,
   input  logic [pcfp_pkg::TICK_WIDTH-1:0]   csr_write_data
);
   import pcfp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences the judging steps; it sees only status flags.
   pcfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the frame bytes, the configuration register and the
   // arithmetic, and keeps the result registers stable while a beat waits.
   pcfp_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_period_reload (rsp_period_reload),
      .rsp_compare_value (rsp_compare_value)
   );

endmodule
